[rtl/dfr_pkg.sv]
// ----------------------------------------------------------------------------
// dfr_pkg
// shared types and constants of the delimited frame receiver
// ----------------------------------------------------------------------------
`default_nettype none

package dfr_pkg;

   // item kinds on the request side
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // end status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_ABORT   = 2'd1;
   localparam logic [1:0] ST_TIMEOUT = 2'd2;

   // delimiter and abort characters
   localparam logic [7:0] CH_LEAD_A = 8'h40;
   localparam logic [7:0] CH_LEAD_B = 8'h7B;
   localparam logic [7:0] CH_END_A  = 8'h7D;
   localparam logic [7:0] CH_END_B  = 8'h40;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_EOF    = 8'hFF;

   localparam int DEF_MAX_FRAME_BYTES = 199;

   localparam int          TIMEOUT_W       = 24;
   localparam logic [23:0] TIMEOUT_RESET   = 24'd100000;

   // result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   typedef struct packed {
      logic       op;
      logic [7:0] rx_byte;
   } item_type;

   typedef struct packed {
      logic       byte_valid;
      logic [7:0] frame_byte;
      logic       frame_end;
      logic [1:0] status;
   } result_type;

   // results produced by one item, first in r0
   typedef struct packed {
      logic [1:0] count;
      result_type r0;
      result_type r1;
   } push_type;

endpackage

`default_nettype wire

[rtl/dfr_core.sv]
// ----------------------------------------------------------------------------
// dfr_core
// frame state and per item decision, one item per cycle while take is high
// ----------------------------------------------------------------------------
`default_nettype none

module dfr_core
   import dfr_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 take,
   input  wire item_type             item,
   input  wire logic [TIMEOUT_W-1:0] timeout_ticks,
   output push_type                  push
);

   logic                 in_body_ff,    in_body_in;
   logic [7:0]           byte_count_ff, byte_count_in;
   logic [7:0]           prev_byte_ff,  prev_byte_in;
   logic                 prev_valid_ff, prev_valid_in;
   logic [TIMEOUT_W-1:0] tick_count_ff, tick_count_in;

   logic [TIMEOUT_W-1:0] tick_sum;
   logic [8:0]           count_sum;
   logic                 count_full;
   logic                 lead_seen;
   logic                 end_seen;
   logic                 abort_char;

   assign tick_sum   = tick_count_ff + TIMEOUT_W'(1);
   assign count_sum  = {1'b0, byte_count_ff} + 9'd1;
   assign count_full = count_sum >= 9'(MAX_FRAME_BYTES);
   assign lead_seen  = prev_valid_ff && prev_byte_ff == CH_LEAD_A
                       && item.rx_byte == CH_LEAD_B;
   assign end_seen   = prev_valid_ff && prev_byte_ff == CH_END_A
                       && item.rx_byte == CH_END_B;
   assign abort_char = item.rx_byte == CH_CR || item.rx_byte == CH_LF
                       || item.rx_byte == CH_EOF;

   always_comb begin
      in_body_in    = in_body_ff;
      byte_count_in = byte_count_ff;
      prev_byte_in  = prev_byte_ff;
      prev_valid_in = prev_valid_ff;
      tick_count_in = tick_count_ff;
      push          = '0;
      if (take) begin
         if (item.op == OP_TICK) begin
            tick_count_in = tick_sum;
            if (tick_sum >= timeout_ticks) begin
               push.count = 2'd1;
               push.r0    = '{1'b0, 8'h00, 1'b1, in_body_ff ? ST_ABORT : ST_TIMEOUT};
            end
         end else if (!in_body_ff) begin
            if (lead_seen) begin
               push.count    = 2'd2;
               push.r0       = '{1'b1, CH_LEAD_A, 1'b0, ST_OK};
               push.r1       = '{1'b1, CH_LEAD_B, 1'b0, ST_OK};
               in_body_in    = 1'b1;
               byte_count_in = 8'd2;
               prev_byte_in  = CH_LEAD_B;
               prev_valid_in = 1'b1;
               tick_count_in = '0;
            end else if (count_full) begin
               push.count = 2'd1;
               push.r0    = '{1'b0, 8'h00, 1'b1, ST_ABORT};
            end else begin
               byte_count_in = count_sum[7:0];
               prev_byte_in  = item.rx_byte;
               prev_valid_in = 1'b1;
            end
         end else begin
            push.count = 2'd1;
            if (end_seen) begin
               push.r0 = '{1'b1, item.rx_byte, 1'b1, ST_OK};
            end else if (abort_char || count_full) begin
               push.r0 = '{1'b1, item.rx_byte, 1'b1, ST_ABORT};
            end else begin
               push.r0       = '{1'b1, item.rx_byte, 1'b0, ST_OK};
               byte_count_in = count_sum[7:0];
               prev_byte_in  = item.rx_byte;
               prev_valid_in = 1'b1;
            end
         end
         // any frame end returns to hunting with cleared counters
         if (push.count == 2'd1 && push.r0.frame_end) begin
            in_body_in    = 1'b0;
            byte_count_in = '0;
            prev_byte_in  = '0;
            prev_valid_in = 1'b0;
            tick_count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_body_ff    <= 1'b0;
         byte_count_ff <= '0;
         prev_byte_ff  <= '0;
         prev_valid_ff <= 1'b0;
         tick_count_ff <= '0;
      end else begin
         in_body_ff    <= in_body_in;
         byte_count_ff <= byte_count_in;
         prev_byte_ff  <= prev_byte_in;
         prev_valid_ff <= prev_valid_in;
         tick_count_ff <= tick_count_in;
      end
   end

endmodule

`default_nettype wire

[rtl/dfr_queue.sv]
// ----------------------------------------------------------------------------
// dfr_queue
// small result queue, takes up to two results a cycle, gives one
// ----------------------------------------------------------------------------
`default_nettype none

module dfr_queue
   import dfr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire push_type    push,
   input  wire logic        pop,
   output result_type       head,
   output logic             not_empty,
   output logic [QUEUE_AW:0] fill
);

   result_type            mem [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     fill_ff,   fill_in;
   logic [QUEUE_AW-1:0]   wr_next;

   assign wr_next   = wr_ptr_ff + QUEUE_AW'(1);
   assign head      = mem[rd_ptr_ff];
   assign not_empty = fill_ff != '0;
   assign fill      = fill_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_AW'(push.count);
      rd_ptr_in = rd_ptr_ff + QUEUE_AW'(pop);
      fill_in   = fill_ff + (QUEUE_AW + 1)'(push.count) - (QUEUE_AW + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ptr_ff] <= push.r0;
      end
      if (push.count == 2'd2) begin
         mem[wr_next] <= push.r1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

`default_nettype wire

[rtl/delimited_frame_receiver_unit.sv]
// ----------------------------------------------------------------------------
// delimited_frame_receiver_unit
// hunts for the lead pair, forwards the frame body, ends with a status
// ----------------------------------------------------------------------------
// path: an accepted item is registered in the input stage, then its results are written into the queue
// throughput: one item per cycle while at most two results wait; a lead pair
//   gives two results, so the input stalls while three or more sit in the four entry queue
// reset: synchronous, clears frame state, queue pointers and input valid, and sets
//   timeout_ticks to 100000
`default_nettype none

module delimited_frame_receiver_unit
   import dfr_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request stream
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [7:0]           req_tdata,   // [7:0] rx_byte
   input  wire logic                 req_tuser,   // [0] op
   // result stream
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [15:0]               rsp_tdata,   // [7:0] frame_byte, [9:8] status
   output logic                      rsp_tlast,   // frame_end
   output logic                      rsp_tuser,   // [0] byte_valid
   // timeout register write
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [TIMEOUT_W-1:0] csr_data
);

   // timeout register, always writable
   logic [TIMEOUT_W-1:0] timeout_ff;
   logic [TIMEOUT_W-1:0] timeout_in;

   assign csr_ready  = 1'b1;
   assign timeout_in = (csr_valid && csr_ready) ? csr_data : timeout_ff;

   // input stage
   logic     in_valid_ff, in_valid_in;
   item_type item_ff,     item_in;
   logic     req_accept;
   logic     take;

   // result queue view
   push_type          push;
   result_type        head;
   logic              not_empty;
   logic [QUEUE_AW:0] fill;
   logic              pop;

   // an item is processed only when the queue has room for a lead pair
   assign take       = in_valid_ff && (fill <= (QUEUE_AW + 1)'(QUEUE_DEPTH - 2));
   assign req_tready = !in_valid_ff || take;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      item_in     = item_ff;
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         item_in     = '{req_tuser, req_tdata};
         in_valid_in = 1'b1;
      end else if (take) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         timeout_ff  <= TIMEOUT_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         timeout_ff  <= timeout_in;
      end
   end

   // payload holds without reset
   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   // per item decision and frame state
   dfr_core #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .take          (take),
      .item          (item_ff),
      .timeout_ticks (timeout_ff),
      .push          (push)
   );

   // results wait here until the rsp side takes them
   assign pop = rsp_tvalid && rsp_tready;

   dfr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty),
      .fill      (fill)
   );

   assign rsp_tvalid = not_empty;
   assign rsp_tdata  = {6'b0, head.status, head.frame_byte};
   assign rsp_tlast  = head.frame_end;
   assign rsp_tuser  = head.byte_valid;

   // queue never holds more than its depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill <= (QUEUE_AW + 1)'(QUEUE_DEPTH))
      else $error("result queue overfilled");

   // a pair of results only follows a lead, never an end
   a_pair_no_end: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> !push.r0.frame_end && !push.r1.frame_end)
      else $error("lead pair marked as frame end");

   // an end without a byte is never a success
   a_empty_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast && !rsp_tuser |-> head.status != ST_OK)
      else $error("empty frame end with success status");

   // status is zero on results that do not end a frame
   a_mid_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> head.status == ST_OK)
      else $error("status set on a mid frame result");

endmodule

`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// feeds received bytes and timer ticks into the frame receiver, predicts
// every frame byte and end status, and compares each result as it drains
// ----------------------------------------------------------------------------

module testbench;
   import dfr_pkg::*;

   localparam int FRAME_LIMIT    = DEF_MAX_FRAME_BYTES;
   localparam int DRAIN_CYCLES   = 8;      // extra wait after the last expected result drains
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_COUNT    = 8;
   localparam int PHASE_ITEMS    = 235;

   localparam result_type NO_RESULT = '0;

   // one line of stimulus: an item or a timeout write, with optional typed results
   typedef struct {
      bit                   is_csr;
      logic [TIMEOUT_W-1:0] csr_value;
      item_type             item;
      bit                   typed;
      int                   n;
      result_type           r0;
      result_type           r1;
   } stim_row_type;

   typedef enum int {DRAIN_FULL, DRAIN_RANDOM, DRAIN_SLOW, DRAIN_TOGGLE} drain_mode_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata  = '0;
   logic                 req_tuser  = OP_BYTE;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [15:0]          rsp_tdata;
   logic                 rsp_tlast;
   logic                 rsp_tuser;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [TIMEOUT_W-1:0] csr_data   = '0;

   always #2 clock = ~clock;

   delimited_frame_receiver_unit #(
      .MAX_FRAME_BYTES(FRAME_LIMIT)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // ---------------------------------------------------------------------
   // frame tracker: own copy of the receiver state
   // ---------------------------------------------------------------------
   bit                   body_active;
   logic [7:0]           frame_count;
   logic [7:0]           last_byte;
   bit                   last_seen;
   logic [TIMEOUT_W-1:0] tick_total;
   logic [TIMEOUT_W-1:0] timeout_limit;

   result_type   pending_results[$];
   stim_row_type phase_rows[$];
   int           error_count = 0;
   int           burst_left  = 0;

   function automatic result_type make_result(bit v, logic [7:0] b, bit e, logic [1:0] st);
      result_type r;
      r.byte_valid = v;
      r.frame_byte = b;
      r.frame_end  = e;
      r.status     = st;
      return r;
   endfunction

   function automatic void hunt_restart();
      body_active = 1'b0;
      frame_count = '0;
      last_byte   = '0;
      last_seen   = 1'b0;
      tick_total  = '0;
   endfunction

   // advances the tracker by one item and returns how many results it causes
   function automatic int frame_step(input item_type it, output result_type r0,
                                     output result_type r1);
      r0 = NO_RESULT;
      r1 = NO_RESULT;
      if (it.op == OP_TICK) begin
         tick_total = tick_total + TIMEOUT_W'(1);
         if (tick_total >= timeout_limit) begin
            // a body timeout counts as an abort, a hunting one has its own code
            r0 = make_result(1'b0, 8'h00, 1'b1, body_active ? ST_ABORT : ST_TIMEOUT);
            hunt_restart();
            return 1;
         end
         return 0;
      end
      if (!body_active) begin
         if (last_seen && last_byte == CH_LEAD_A && it.rx_byte == CH_LEAD_B) begin
            r0 = make_result(1'b1, CH_LEAD_A, 1'b0, ST_OK);
            r1 = make_result(1'b1, CH_LEAD_B, 1'b0, ST_OK);
            body_active = 1'b1;
            frame_count = 8'd2;
            last_byte   = CH_LEAD_B;
            last_seen   = 1'b1;
            tick_total  = '0;
            return 2;
         end
         frame_count = frame_count + 8'd1;
         if (int'(frame_count) > FRAME_LIMIT - 1) begin
            r0 = make_result(1'b0, 8'h00, 1'b1, ST_ABORT);
            hunt_restart();
            return 1;
         end
         last_byte = it.rx_byte;
         last_seen = 1'b1;
         return 0;
      end
      // end code wins over the abort characters
      if (last_seen && last_byte == CH_END_A && it.rx_byte == CH_END_B) begin
         r0 = make_result(1'b1, it.rx_byte, 1'b1, ST_OK);
         hunt_restart();
         return 1;
      end
      if (it.rx_byte == CH_CR || it.rx_byte == CH_LF || it.rx_byte == CH_EOF) begin
         r0 = make_result(1'b1, it.rx_byte, 1'b1, ST_ABORT);
         hunt_restart();
         return 1;
      end
      frame_count = frame_count + 8'd1;
      if (int'(frame_count) > FRAME_LIMIT - 1) begin
         r0 = make_result(1'b1, it.rx_byte, 1'b1, ST_ABORT);
         hunt_restart();
         return 1;
      end
      last_byte = it.rx_byte;
      last_seen = 1'b1;
      r0 = make_result(1'b1, it.rx_byte, 1'b0, ST_OK);
      return 1;
   endfunction

   // ---------------------------------------------------------------------
   // stimulus rows
   // ---------------------------------------------------------------------
   function automatic stim_row_type row_item(logic op, logic [7:0] b);
      stim_row_type row;
      row.is_csr       = 1'b0;
      row.csr_value    = '0;
      row.item.op      = op;
      row.item.rx_byte = b;
      row.typed        = 1'b0;
      row.n            = 0;
      row.r0           = NO_RESULT;
      row.r1           = NO_RESULT;
      return row;
   endfunction

   function automatic stim_row_type row_typed(logic op, logic [7:0] b, int n,
                                              result_type r0, result_type r1);
      stim_row_type row;
      row       = row_item(op, b);
      row.typed = 1'b1;
      row.n     = n;
      row.r0    = r0;
      row.r1    = r1;
      return row;
   endfunction

   function automatic stim_row_type row_csr(logic [TIMEOUT_W-1:0] v);
      stim_row_type row;
      row           = row_item(OP_BYTE, 8'h00);
      row.is_csr    = 1'b1;
      row.csr_value = v;
      return row;
   endfunction

   // sender: bursts of random length, random gaps, valid held across a burst
   task automatic send_row(input stim_row_type row);
      result_type p0;
      result_type p1;
      int         n;
      int         gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= row.item.rx_byte;
      req_tuser  <= row.item.op;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      n = frame_step(row.item, p0, p1);
      if (row.typed) begin
         n  = row.n;
         p0 = row.r0;
         p1 = row.r1;
      end
      if (n > 0) pending_results.push_back(p0);
      if (n > 1) pending_results.push_back(p1);
   endtask

   // timeout writes only once the receiver has gone quiet
   task automatic write_timeout(input logic [TIMEOUT_W-1:0] v);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      timeout_limit = v;
      burst_left    = 0;
   endtask

   function automatic logic [7:0] body_byte();
      logic [7:0] b;
      b = 8'($urandom);
      // mostly keep the body going, now and then let an abort character through
      if ((b == CH_CR || b == CH_LF || b == CH_EOF) && $urandom_range(0, 9) != 0)
         b = b ^ 8'h20;
      return b;
   endfunction

   function automatic logic [7:0] abort_byte();
      case ($urandom_range(0, 2))
         0:       return CH_CR;
         1:       return CH_LF;
         default: return CH_EOF;
      endcase
   endfunction

   task automatic add_byte(input logic [7:0] b);
      phase_rows.push_back(row_item(OP_BYTE, b));
   endtask

   task automatic add_tick();
      phase_rows.push_back(row_item(OP_TICK, 8'($urandom)));
   endtask

   // mostly well formed frames with random bodies, plus noise and long hunts
   task automatic build_phase(input int target);
      int         kind;
      int         pick;
      int         body_len;
      logic [7:0] b;
      phase_rows.delete();
      while (phase_rows.size() < target) begin
         kind = $urandom_range(0, 99);
         if (kind < 72) begin
            repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
            add_byte(CH_LEAD_A);
            add_byte(CH_LEAD_B);
            pick = $urandom_range(0, 99);
            if (pick < 4)       body_len = $urandom_range(190, 200);   // length limit
            else if (pick < 12) body_len = $urandom_range(25, 80);
            else                body_len = $urandom_range(0, 24);
            repeat (body_len) begin
               if ($urandom_range(0, 9) == 0) add_tick();
               add_byte(body_byte());
            end
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               add_byte(CH_END_A);
               add_byte(CH_END_B);
            end else if (pick < 85) begin
               add_byte(abort_byte());
            end
         end else if (kind < 97) begin
            repeat ($urandom_range(1, 12)) begin
               if ($urandom_range(0, 9) < 3) add_tick();
               else add_byte(8'($urandom));
            end
         end else begin
            // no lead character at all, so hunting runs into the byte limit
            repeat ($urandom_range(195, 205)) begin
               b = 8'($urandom);
               if (b == CH_LEAD_A) b = 8'h41;
               add_byte(b);
            end
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // result side: stall pattern and checking
   // ---------------------------------------------------------------------
   drain_mode_type drain_mode = DRAIN_FULL;
   int             mode_left  = 0;
   int             idle_count = 0;

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin : result_check
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser, rsp_tdata[7:0], rsp_tlast, rsp_tdata[9:8]};
         if (pending_results.size() == 0) begin
            error_count++;
            $display("%0t ns: unexpected result, expected none actual %p", $time, got);
         end else begin
            want = pending_results.pop_front();
            check_field("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
            check_field("frame_byte", want.frame_byte, got.frame_byte);
            check_field("frame_end",  8'(want.frame_end),  8'(got.frame_end));
            check_field("status",     8'(want.status),     8'(got.status));
         end
      end
      if (mode_left == 0) begin
         drain_mode = drain_mode_type'($urandom_range(0, 3));
         mode_left  = $urandom_range(16, 64);
      end else begin
         mode_left--;
      end
      case (drain_mode)
         DRAIN_FULL:   rsp_tready <= 1'b1;
         DRAIN_RANDOM: rsp_tready <= 1'($urandom_range(0, 1));
         DRAIN_SLOW:   rsp_tready <= ($urandom_range(0, 3) == 0);
         default:      rsp_tready <= ~rsp_tready;
      endcase
   end

   // watchdog on cycles in which no channel moves anything
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_count = 0;
         else
            idle_count++;
         if (idle_count >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no progress for %0d cycles", $time, idle_count);
            $display("** delimited_frame_receiver_unit: FAILED **");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin : main_flow
      stim_row_type         dir_rows[$];
      logic [TIMEOUT_W-1:0] phase_timeout[PHASE_COUNT];

      hunt_restart();
      timeout_limit = TIMEOUT_RESET;

      // directed part, starting from the reset timeout
      dir_rows.push_back(row_typed(OP_BYTE, CH_LEAD_A, 0, NO_RESULT, NO_RESULT));
      dir_rows.push_back(row_typed(OP_BYTE, CH_LEAD_B, 2,
                                   make_result(1'b1, CH_LEAD_A, 1'b0, ST_OK),
                                   make_result(1'b1, CH_LEAD_B, 1'b0, ST_OK)));
      dir_rows.push_back(row_typed(OP_BYTE, 8'h00, 1,
                                   make_result(1'b1, 8'h00, 1'b0, ST_OK), NO_RESULT));
      dir_rows.push_back(row_typed(OP_BYTE, CH_END_A, 1,
                                   make_result(1'b1, CH_END_A, 1'b0, ST_OK), NO_RESULT));
      dir_rows.push_back(row_typed(OP_BYTE, CH_END_B, 1,
                                   make_result(1'b1, CH_END_B, 1'b1, ST_OK), NO_RESULT));
      // tick far below the timeout, its data byte is ignored
      dir_rows.push_back(row_typed(OP_TICK, 8'hFF, 0, NO_RESULT, NO_RESULT));
      dir_rows.push_back(row_item(OP_BYTE, CH_LEAD_A));
      dir_rows.push_back(row_item(OP_BYTE, CH_LEAD_B));
      dir_rows.push_back(row_typed(OP_BYTE, CH_CR, 1,
                                   make_result(1'b1, CH_CR, 1'b1, ST_ABORT), NO_RESULT));
      dir_rows.push_back(row_item(OP_BYTE, CH_LEAD_A));
      dir_rows.push_back(row_item(OP_BYTE, CH_LEAD_B));
      dir_rows.push_back(row_typed(OP_BYTE, CH_LF, 1,
                                   make_result(1'b1, CH_LF, 1'b1, ST_ABORT), NO_RESULT));
      dir_rows.push_back(row_item(OP_BYTE, CH_LEAD_A));
      dir_rows.push_back(row_item(OP_BYTE, CH_LEAD_B));
      dir_rows.push_back(row_typed(OP_BYTE, CH_EOF, 1,
                                   make_result(1'b1, CH_EOF, 1'b1, ST_ABORT), NO_RESULT));
      // doubled lead character still pairs with the brace
      dir_rows.push_back(row_item(OP_BYTE, CH_LEAD_A));
      dir_rows.push_back(row_item(OP_BYTE, CH_LEAD_A));
      dir_rows.push_back(row_typed(OP_BYTE, CH_LEAD_B, 2,
                                   make_result(1'b1, CH_LEAD_A, 1'b0, ST_OK),
                                   make_result(1'b1, CH_LEAD_B, 1'b0, ST_OK)));
      dir_rows.push_back(row_item(OP_BYTE, CH_END_A));
      dir_rows.push_back(row_item(OP_BYTE, CH_END_B));
      // one tick timeout: hunting timeout, then body timeout
      dir_rows.push_back(row_csr(24'd1));
      dir_rows.push_back(row_typed(OP_TICK, 8'h00, 1,
                                   make_result(1'b0, 8'h00, 1'b1, ST_TIMEOUT), NO_RESULT));
      dir_rows.push_back(row_item(OP_BYTE, CH_LEAD_A));
      dir_rows.push_back(row_item(OP_BYTE, CH_LEAD_B));
      dir_rows.push_back(row_typed(OP_TICK, 8'h00, 1,
                                   make_result(1'b0, 8'h00, 1'b1, ST_ABORT), NO_RESULT));
      // zero timeout expires on the first tick
      dir_rows.push_back(row_csr(24'd0));
      dir_rows.push_back(row_typed(OP_TICK, 8'h5A, 1,
                                   make_result(1'b0, 8'h00, 1'b1, ST_TIMEOUT), NO_RESULT));
      dir_rows.push_back(row_csr(24'hFFFFFF));

      phase_timeout[0] = 24'd1;
      phase_timeout[1] = 24'hFFFFFF;
      phase_timeout[2] = 24'd3;
      phase_timeout[3] = TIMEOUT_W'($urandom_range(2, 12));
      phase_timeout[4] = 24'd6;
      phase_timeout[5] = TIMEOUT_W'($urandom_range(1, 40));
      phase_timeout[6] = 24'd20;
      phase_timeout[7] = 24'hFFFFFF;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_csr) write_timeout(dir_rows[i].csr_value);
         else send_row(dir_rows[i]);
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_timeout(phase_timeout[p]);
         build_phase(PHASE_ITEMS);
         foreach (phase_rows[i]) send_row(phase_rows[i]);
      end

      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("** delimited_frame_receiver_unit: PASSED **");
      end else begin
         $display("** delimited_frame_receiver_unit: FAILED **");
      end
      $finish;
   end

endmodule
